@@ hdl/dfa_pkg.sv @@
package dfa_pkg;

  localparam int TABLE_ROWS  = 64;
  localparam int NUM_SYMBOLS = 256;

  localparam int STATE_W = $clog2(TABLE_ROWS);
  localparam int SYM_W   = $clog2(NUM_SYMBOLS);
  localparam int ADDR_W  = STATE_W + SYM_W;
  localparam int DEPTH   = TABLE_ROWS * NUM_SYMBOLS;
  localparam int ENTRY_W = STATE_W + 1;
  localparam int CNT_W   = 7;

  typedef enum logic [1:0] {
    OP_STEP    = 2'd0,
    OP_ADD     = 2'd1,
    OP_MARK    = 2'd2,
    OP_RESTART = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

endpackage

@@ hdl/table_driven_dfa_engine_unit.sv @@
// Table-driven automaton. Each transfer on the input channel carries one item
// (step, add transition, mark accepting, restart) and yields exactly one result
// transfer reporting the state after the item, its accept flag, a fall-back
// flag and a status code. The transition table is a single-port-write,
// single-port-read memory of TABLE_ROWS*NUM_SYMBOLS entries (valid bit plus
// destination); the accept flags sit in a second memory of TABLE_ROWS bits.
// An item is taken whenever no sweep runs and the item stage can move on: the
// table is read at the transfer edge, the result is formed from the staged item
// and held in the output register, whose accept bit is the registered read of
// the flag memory or-ed with a forwarded mark. Throughput is one item per cycle
// while the result channel does not stall; the limiting path is the table read
// data through the next-state select back into the read address of the next
// step. After reset the table and the accept flags are swept clear, one table
// entry a cycle, and in_ready stays low meanwhile. Writing state_count sweeps
// the table rows and flags at or above the new bound, again with in_ready low.
module table_driven_dfa_engine_unit import dfa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [CNT_W-1:0]   cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic [SYM_W-1:0]   symbol,
  input  logic [STATE_W-1:0] from_state,
  input  logic [STATE_W-1:0] to_state,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [STATE_W-1:0] present_state,
  output logic               accepting,
  output logic               fell_back,
  output logic [1:0]         status
);

  localparam logic [CNT_W-1:0] MAX_BOUND = CNT_W'(TABLE_ROWS);

  // Configuration and architectural state
  logic [CNT_W-1:0]      state_count;
  logic                  accept_mem [TABLE_ROWS];
  logic [STATE_W-1:0]    cur_state;

  // Table memory and clearing sweep
  logic [ENTRY_W-1:0] tbl_mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data;
  logic               clr_active;
  logic [ADDR_W:0]    clr_addr;

  // Item stage
  logic               s1_valid;
  op_t                s1_op;
  logic [SYM_W-1:0]   s1_sym;
  logic [STATE_W-1:0] s1_from;
  logic [STATE_W-1:0] s1_to;
  logic               fwd_hit;
  logic [STATE_W-1:0] fwd_dest;

  logic               in_xfer;
  logic               s1_adv;
  logic [CNT_W-1:0]   bound;
  logic [CNT_W-1:0]   new_bound;
  logic [ADDR_W:0]    new_clr_start;
  logic               ent_valid;
  logic [STATE_W-1:0] ent_dest;
  logic               from_ok;
  logic               to_ok;
  logic [STATE_W-1:0] state_after;
  logic               res_fell;
  status_t            res_status;
  logic               item_we;
  logic               mark_we;
  logic [ADDR_W-1:0]  item_waddr;
  logic [ADDR_W-1:0]  rd_addr;
  logic [STATE_W-1:0] addr_state;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               acc_we;
  logic [STATE_W-1:0] acc_waddr;
  logic               acc_wdata;
  logic               acc_rd;
  logic               acc_fwd;

  // Saturate the state count to the table's row count
  assign bound     = (state_count > MAX_BOUND) ? MAX_BOUND : state_count;
  assign new_bound = (cfg_wdata > MAX_BOUND) ? MAX_BOUND : cfg_wdata;
  assign new_clr_start = {new_bound[STATE_W:0], {SYM_W{1'b0}}};

  // Pipeline control: the stage moves on whenever the output register is free
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !clr_active && (!s1_valid || s1_adv);
  assign in_xfer  = in_valid && in_ready;

  // Entry seen by the staged item, with a same-edge write forwarded
  assign ent_valid = fwd_hit || rd_data[ENTRY_W-1];
  assign ent_dest  = fwd_hit ? fwd_dest : rd_data[STATE_W-1:0];

  assign from_ok = {1'b0, s1_from} < bound;
  assign to_ok   = {1'b0, s1_to} < bound;

  always_comb begin
    state_after = cur_state;
    res_fell    = 1'b0;
    res_status  = ST_OK;
    item_we     = 1'b0;
    mark_we     = 1'b0;
    unique case (s1_op)
      OP_STEP: begin
        if (ent_valid) begin
          state_after = ent_dest;
        end else begin
          state_after = '0;
          res_fell    = 1'b1;
        end
      end
      OP_ADD: begin
        if (!from_ok || !to_ok) begin
          res_status = ST_RANGE;
        end else if (ent_valid) begin
          res_status = ST_DUP;
        end else begin
          item_we = 1'b1;
        end
      end
      OP_MARK: begin
        if (!from_ok) begin
          res_status = ST_RANGE;
        end else begin
          mark_we = 1'b1;
        end
      end
      OP_RESTART: begin
        state_after = '0;
      end
      default: begin
        state_after = cur_state;
      end
    endcase
  end

  assign item_waddr = {s1_from, s1_sym};

  // Next read address: the staged item's new state when it retires this edge
  assign addr_state = s1_valid ? state_after : cur_state;
  assign rd_addr    = (op_t'(op) == OP_STEP) ? {addr_state, symbol} : {from_state, symbol};

  // Memory write ports: sweep has priority, no new item enters while it runs
  always_comb begin
    if (clr_active) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr[ADDR_W-1:0];
      mem_wdata = '0;
      acc_we    = 1'b1;
      acc_waddr = clr_addr[ADDR_W-1:SYM_W];
      acc_wdata = 1'b0;
    end else begin
      mem_we    = s1_adv && item_we;
      mem_waddr = item_waddr;
      mem_wdata = {1'b1, s1_to};
      acc_we    = s1_adv && mark_we;
      acc_waddr = s1_from;
      acc_wdata = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem[mem_waddr] <= mem_wdata;
    end
    if (in_xfer) begin
      rd_data <= tbl_mem[rd_addr];
    end
  end

  // Accept flags: read the flag of the state the item leaves the machine in
  always_ff @(posedge clk) begin
    if (acc_we) begin
      accept_mem[acc_waddr] <= acc_wdata;
    end
    if (s1_adv) begin
      acc_rd <= accept_mem[state_after];
    end
  end

  // Item stage payload and forward of a write that lands on the read edge
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op    <= op_t'(op);
      s1_sym   <= symbol;
      s1_from  <= from_state;
      s1_to    <= to_state;
      fwd_hit  <= s1_adv && item_we && (item_waddr == rd_addr);
      fwd_dest <= s1_to;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // Retire the staged item: commit state and flags, load the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_state <= '0;
      out_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        cur_state <= state_after;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A mark of the state we sit in shows in this very result
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      present_state <= state_after;
      acc_fwd       <= mark_we && (s1_from == state_after);
      fell_back     <= res_fell;
      status        <= res_status;
    end
  end

  assign accepting = acc_rd || acc_fwd;

  // Configuration register and clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state_count <= MAX_BOUND;
      clr_active  <= 1'b1;
      clr_addr    <= '0;
    end else if (cfg_wen) begin
      state_count <= cfg_wdata;
      // Restart from the lower of the pending position and the new first row
      if (clr_active && (clr_addr < new_clr_start)) begin
        clr_addr <= clr_addr;
      end else begin
        clr_addr   <= new_clr_start;
        clr_active <= clr_active || (new_clr_start < (ADDR_W+1)'(DEPTH));
      end
    end else if (clr_active) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == (ADDR_W+1)'(DEPTH - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

endmodule

@@ sim/tb_table_driven_dfa_engine_unit.sv @@
`timescale 1ns / 1ps

module tb_table_driven_dfa_engine_unit import dfa_pkg::*; ();

  // Cycles without any transfer before the run is declared hung. It must
  // outlast the reset clearing pass and the widest state_count sweep.
  localparam int STALL_LIMIT = 60000;
  localparam int SHOWN_MISMATCHES = 10;

  typedef struct packed {
    op_t                op;
    logic [SYM_W-1:0]   symbol;
    logic [STATE_W-1:0] from_state;
    logic [STATE_W-1:0] to_state;
  } dfa_item_t;

  typedef struct packed {
    logic [STATE_W-1:0] state;
    logic               accepting;
    logic               fell_back;
    status_t            status;
  } dfa_report_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wen = 1'b0;
  logic [CNT_W-1:0]   cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         op;
  logic [SYM_W-1:0]   symbol;
  logic [STATE_W-1:0] from_state;
  logic [STATE_W-1:0] to_state;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [STATE_W-1:0] present_state;
  logic               accepting;
  logic               fell_back;
  logic [1:0]         status;

  // Item currently presented on the input channel; the payload ports follow it.
  dfa_item_t item_on_bus = '0;

  assign op         = item_on_bus.op;
  assign symbol     = item_on_bus.symbol;
  assign from_state = item_on_bus.from_state;
  assign to_state   = item_on_bus.to_state;

  // Shadow copy of the automaton: table entries are valid bit plus destination.
  bit [ENTRY_W-1:0]   shadow_table [DEPTH];
  bit                 shadow_accept [TABLE_ROWS];
  logic [STATE_W-1:0] shadow_state = '0;
  logic [CNT_W-1:0]   shadow_count = CNT_W'(TABLE_ROWS);

  dfa_item_t   items_to_send [$];
  dfa_report_t reports_due [$];

  int  mismatches = 0;
  int  idle_cycles = 0;
  // Set for one phase to switch off all random idling on both channels.
  bit  steady = 1'b0;

  table_driven_dfa_engine_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .symbol        (symbol),
    .from_state    (from_state),
    .to_state      (to_state),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .present_state (present_state),
    .accepting     (accepting),
    .fell_back     (fell_back),
    .status        (status)
  );

  always #5 clk = ~clk;

  // Number of states in range; values above TABLE_ROWS saturate.
  function automatic int live_bound();
    return (int'(shadow_count) > TABLE_ROWS) ? TABLE_ROWS : int'(shadow_count);
  endfunction

  // Apply one item to the shadow automaton and return the report it causes.
  function automatic dfa_report_t advance_automaton(dfa_item_t it);
    dfa_report_t rep;
    int          bound;
    int          slot;
    bound = live_bound();
    rep.fell_back = 1'b0;
    rep.status = ST_OK;
    case (it.op)
      OP_STEP: begin
        slot = int'(shadow_state) * NUM_SYMBOLS + int'(it.symbol);
        if (shadow_table[slot][STATE_W]) begin
          shadow_state = shadow_table[slot][STATE_W-1:0];
        end else begin
          // No transition stored: fall back to the start state.
          shadow_state = '0;
          rep.fell_back = 1'b1;
        end
      end
      OP_ADD: begin
        slot = int'(it.from_state) * NUM_SYMBOLS + int'(it.symbol);
        // Range is checked first; only an in-range add can be a duplicate.
        if (int'(it.from_state) >= bound || int'(it.to_state) >= bound) begin
          rep.status = ST_RANGE;
        end else if (shadow_table[slot][STATE_W]) begin
          rep.status = ST_DUP;
        end else begin
          shadow_table[slot] = {1'b1, it.to_state};
        end
      end
      OP_MARK: begin
        if (int'(it.from_state) >= bound) rep.status = ST_RANGE;
        else shadow_accept[it.from_state] = 1'b1;
      end
      default: begin
        shadow_state = '0;
      end
    endcase
    rep.state = shadow_state;
    rep.accepting = shadow_accept[shadow_state];
    return rep;
  endfunction

  // Mostly pick from the first few states so that steps find transitions;
  // sometimes anywhere in range, sometimes any 6-bit value.
  function automatic logic [STATE_W-1:0] pick_state(int bound);
    int roll;
    int near;
    roll = $urandom_range(0, 99);
    near = (bound < 8) ? bound : 8;
    if (bound == 0 || roll >= 85) return STATE_W'($urandom);
    if (roll < 60) return STATE_W'($urandom_range(0, near - 1));
    return STATE_W'($urandom_range(0, bound - 1));
  endfunction

  function automatic dfa_item_t draw_item();
    dfa_item_t it;
    int        roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) it.op = OP_STEP;
    else if (roll < 78) it.op = OP_ADD;
    else if (roll < 90) it.op = OP_MARK;
    else it.op = OP_RESTART;
    // A small alphabet keeps the table dense enough for long walks.
    if ($urandom_range(0, 9) < 8) it.symbol = SYM_W'($urandom_range(0, 7));
    else it.symbol = SYM_W'($urandom);
    it.from_state = pick_state(live_bound());
    it.to_state = pick_state(live_bound());
    return it;
  endfunction

  task automatic queue_item(op_t o, int sym, int src, int dst);
    dfa_item_t it;
    it.op = o;
    it.symbol = SYM_W'(sym);
    it.from_state = STATE_W'(src);
    it.to_state = STATE_W'(dst);
    items_to_send.push_back(it);
  endtask

  task automatic queue_random(int count);
    repeat (count) items_to_send.push_back(draw_item());
  endtask

  // Hold until every queued item has been transferred and every report has
  // come back, then let the pipeline settle.
  task automatic drain();
    @(negedge clk);
    while (items_to_send.size() != 0 || in_valid || reports_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write state_count while idle and mirror the row clearing in the shadow.
  task automatic write_state_count(logic [CNT_W-1:0] value);
    int bound;
    drain();
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    shadow_count = value;
    bound = live_bound();
    for (int s = bound; s < TABLE_ROWS; s++) begin
      shadow_accept[s] = 1'b0;
      for (int c = 0; c < NUM_SYMBOLS; c++) shadow_table[s * NUM_SYMBOLS + c] = '0;
    end
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  // Driver: present the next pending item once the previous one has been
  // transferred, idling at random unless the steady phase is on.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (items_to_send.size() != 0 && (steady || $urandom_range(0, 99) >= 29)) begin
        item_on_bus <= items_to_send.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result transfer against the oldest due report, then
  // predict the report for any input transfer on this edge. Also stall the
  // result channel at random and watch for a hung block.
  always @(posedge clk) begin : monitor
    dfa_report_t due;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (reports_due.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_MISMATCHES)
            $display("unexpected result: state %0d acc %0b fell %0b status %0d",
                     present_state, accepting, fell_back, status);
        end else begin
          due = reports_due.pop_front();
          if (present_state !== due.state || accepting !== due.accepting ||
              fell_back !== due.fell_back || status !== due.status) begin
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES)
              $display("mismatch: expected state %0d acc %0b fell %0b status %0d,",
                       due.state, due.accepting, due.fell_back, due.status,
                       " got state %0d acc %0b fell %0b status %0d",
                       present_state, accepting, fell_back, status);
          end
        end
      end
      if (in_valid && in_ready) reports_due.push_back(advance_automaton(item_on_bus));
      out_ready <= steady || ($urandom_range(0, 99) >= 29);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("table_driven_dfa_engine_unit test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // Hold off until the reset clearing pass is over.
    @(negedge clk);
    while (!in_ready) @(negedge clk);

    // Full range of states.
    write_state_count(CNT_W'(64));
    queue_item(OP_STEP, 8'h00, 0, 0);      // empty table: fall back
    queue_item(OP_ADD, 8'h00, 0, 1);
    queue_item(OP_ADD, 8'h00, 0, 1);       // duplicate, same destination
    queue_item(OP_ADD, 8'h00, 0, 5);       // duplicate, other destination
    queue_item(OP_ADD, 8'hFF, 1, 63);
    queue_item(OP_ADD, 8'hAA, 63, 0);
    queue_item(OP_MARK, 0, 63, 0);
    queue_item(OP_MARK, 0, 63, 63);        // marking twice is fine
    queue_item(OP_STEP, 8'h00, 0, 0);
    queue_item(OP_STEP, 8'hFF, 63, 63);    // lands in an accepting state
    queue_item(OP_STEP, 8'hAA, 0, 0);
    queue_item(OP_STEP, 8'h80, 0, 0);      // no transition from state 0
    queue_item(OP_MARK, 0, 0, 0);
    queue_item(OP_STEP, 8'h00, 0, 0);
    queue_item(OP_RESTART, 8'hFF, 63, 63);
    queue_item(OP_STEP, 8'h00, 0, 0);
    queue_item(OP_STEP, 8'hFF, 0, 0);      // leave the machine in state 63

    // One state: current state and transitions into cleared rows are kept.
    write_state_count(CNT_W'(1));
    queue_item(OP_STEP, 8'hAA, 0, 0);      // row of state 63 was cleared
    queue_item(OP_ADD, 8'h01, 0, 0);
    queue_item(OP_ADD, 8'h01, 1, 0);       // source out of range
    queue_item(OP_ADD, 8'h02, 0, 1);       // destination out of range
    queue_item(OP_ADD, 8'h01, 0, 0);       // duplicate
    queue_item(OP_MARK, 0, 1, 0);          // out of range
    queue_item(OP_STEP, 8'h00, 0, 0);      // old transition into state 1
    queue_item(OP_STEP, 8'h00, 0, 0);      // state 1 has no row left
    queue_random(40);

    // No state in range: every add and mark is refused.
    write_state_count(CNT_W'(0));
    queue_item(OP_ADD, 8'h00, 0, 0);
    queue_item(OP_MARK, 0, 0, 0);
    queue_random(40);

    // Above the state count limit: saturates. Run this phase with no idling.
    write_state_count(CNT_W'(127));
    drain();
    steady = 1'b1;
    queue_random(200);
    drain();
    steady = 1'b0;

    write_state_count(CNT_W'($urandom_range(2, 63)));
    queue_random(150);

    write_state_count(CNT_W'(64));
    queue_random(180);

    drain();
    repeat (16) @(negedge clk);
    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("table_driven_dfa_engine_unit test passed");
    end else begin
      $display("table_driven_dfa_engine_unit test failed");
    end
    $finish;
  end

endmodule
